FILE: sv/cfc_pkg.sv
// ---------------------------------------------------------------------------
// cfc_pkg: shared types and constants of the CRC-16 frame checker
// Frame constants, status codes, word structs and the byte-wide CRC update.
// ---------------------------------------------------------------------------
`default_nettype none

package cfc_pkg;

    localparam int DATA_W  = 8;
    localparam int COUNT_W = 9;
    localparam int STAT_W  = 2;
    localparam int CRC_W   = 16;

    localparam logic [DATA_W-1:0]  HEADER_BYTE = 8'hA5;
    localparam logic [CRC_W-1:0]   CRC_INIT    = 16'hFFFF;
    localparam logic [CRC_W-1:0]   CRC_POLY    = 16'h1021;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 9'd511;
    localparam logic [COUNT_W-1:0] HEADER_LEN  = 9'd4;
    localparam logic [COUNT_W-1:0] LENGTH_POS  = 9'd4;
    localparam logic [COUNT_W-1:0] CRC_START   = 9'd6;
    localparam logic [COUNT_W-1:0] MIN_FRAME   = 9'd6;
    localparam logic [COUNT_W-1:0] LEN_OFFSET  = 9'd5;

    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_HEADER = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_LENGTH = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_CRC    = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              frame_end;
    } byte_word_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [COUNT_W-1:0] frame_bytes;
    } result_word_t;

    // MSB-first CRC-16 update over one byte, no reflection
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [DATA_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[CRC_W-1])
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: sv/cfc_frame_core.sv
// ---------------------------------------------------------------------------
// cfc_frame_core: per-frame state and status decision
// Holds counter, header flag, length byte, running CRC and the two-byte tail.
// ---------------------------------------------------------------------------
`default_nettype none

module cfc_frame_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  fire,
    input  wire cfc_pkg::byte_word_t   word,
    output cfc_pkg::result_word_t      result
);
    import cfc_pkg::*;

    logic [COUNT_W-1:0] byte_index_reg, byte_index_next;
    logic               header_bad_reg, header_bad_next;
    logic [DATA_W-1:0]  length_reg, length_next;
    logic [CRC_W-1:0]   crc_reg, crc_next;
    logic [DATA_W-1:0]  tail0_reg, tail0_next;
    logic [DATA_W-1:0]  tail1_reg, tail1_next;
    logic [COUNT_W-1:0] len_total;

    always_comb
    begin
        byte_index_next = (byte_index_reg >= COUNT_MAX) ? COUNT_MAX
                                                        : byte_index_reg + 9'd1;
        header_bad_next = header_bad_reg;
        if (byte_index_reg < HEADER_LEN && word.data_byte != HEADER_BYTE)
            header_bad_next = 1'b1;
        length_next = (byte_index_reg == LENGTH_POS) ? word.data_byte : length_reg;
        crc_next = (byte_index_reg >= CRC_START) ? crc_byte(crc_reg, tail0_reg)
                                                 : crc_reg;
        tail0_next = tail1_reg;
        tail1_next = word.data_byte;
    end

    assign len_total = {1'b0, length_next} + LEN_OFFSET;

    always_comb
    begin
        result.frame_bytes = byte_index_next;
        if (byte_index_next < MIN_FRAME)
            result.status = ST_BAD_LENGTH;
        else if (header_bad_next)
            result.status = ST_BAD_HEADER;
        else if (len_total != byte_index_next)
            result.status = ST_BAD_LENGTH;
        else if ({tail0_next, tail1_next} != crc_next)
            result.status = ST_BAD_CRC;
        else
            result.status = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
            header_bad_reg <= 1'b0;
            length_reg     <= '0;
            crc_reg        <= CRC_INIT;
            tail0_reg      <= '0;
            tail1_reg      <= '0;
        end
        else if (fire)
        begin
            if (word.frame_end)
            begin
                // re-arm for the next frame
                byte_index_reg <= '0;
                header_bad_reg <= 1'b0;
                length_reg     <= '0;
                crc_reg        <= CRC_INIT;
                tail0_reg      <= '0;
                tail1_reg      <= '0;
            end
            else
            begin
                byte_index_reg <= byte_index_next;
                header_bad_reg <= header_bad_next;
                length_reg     <= length_next;
                crc_reg        <= crc_next;
                tail0_reg      <= tail0_next;
                tail1_reg      <= tail1_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/crc16_frame_checker_unit.sv
// ---------------------------------------------------------------------------
// crc16_frame_checker_unit: byte-serial CRC-16 frame checker
// Checks header, length byte and CRC-16 of each frame, one status per frame.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one frame byte per word plus
//   frame_end marking the last byte of a frame. Output channel
//   (out_valid / out_stall) carries one word per frame: status
//   (ok, bad header, bad length, bad crc) and frame_bytes, the byte count of
//   the frame saturating at 511.
//   Timing: an accepted word sits in the input register; the frame state is
//   then updated from it and, for a frame_end word, the result register is
//   loaded, which raises out_valid.
//   Throughput: one byte per cycle, except while a frame_end byte waits for
//   the result register; the byte-wide CRC update sits between the input
//   register and the frame state.
//   Reset clears all frame state (CRC to 0xFFFF) and both valid flags.
//   When the receiver stalls, the result register holds; non-final bytes
//   keep flowing, and a frame_end byte waits in the input register with
//   in_stall raised until the result register frees.
// ---------------------------------------------------------------------------
`default_nettype none

module crc16_frame_checker_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output      logic                         in_stall,
    input  wire logic [cfc_pkg::DATA_W-1:0]   data_byte,
    input  wire logic                         frame_end,
    output      logic                         out_valid,
    input  wire logic                         out_stall,
    output      logic [cfc_pkg::STAT_W-1:0]   status,
    output      logic [cfc_pkg::COUNT_W-1:0]  frame_bytes
);
    import cfc_pkg::*;

    logic         in_valid_reg;
    byte_word_t   in_word_reg;
    logic         out_valid_reg;
    result_word_t out_word_reg;
    result_word_t core_result;
    logic         out_free;
    logic         core_fire;
    logic         in_take;

    // result register frees when empty or being taken this cycle
    assign out_free  = !out_valid_reg || !out_stall;
    // non-final bytes never need the result register
    assign core_fire = in_valid_reg && (!in_word_reg.frame_end || out_free);
    assign in_stall  = in_valid_reg && !core_fire;
    assign in_take   = in_valid && !in_stall;

    cfc_frame_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (core_fire),
        .word   (in_word_reg),
        .result (core_result)
    );

    // input register: advance on accept, drop when consumed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (core_fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_word_reg.data_byte <= data_byte;
            in_word_reg.frame_end <= frame_end;
        end
    end

    // result register: load on a finished frame, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (core_fire && in_word_reg.frame_end)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (core_fire && in_word_reg.frame_end)
            out_word_reg <= core_result;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_word_reg.status;
    assign frame_bytes = out_word_reg.frame_bytes;

endmodule

`default_nettype wire
